@@ rtl/core/tscr_pkg.sv @@
// Shared widths and constants of the TDMA slot channel reserver.
`timescale 1ns / 1ps

package tscr_pkg;

   // Field widths of the request, response and length register
   localparam int unsigned START_W  = 12;
   localparam int unsigned CHAN_W   = 4;
   localparam int unsigned PERIOD_W = 12;
   localparam int unsigned LEN_W    = 13;

   // Walk pointer: holds length plus one period without wrapping
   localparam int unsigned WALK_W = 14;

   // Superframe length after reset
   localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

endpackage

@@ rtl/core/tscr_req_if.sv @@
// Request channel interface: start slot, channel and repeat period.
`timescale 1ns / 1ps

interface tscr_req_if
   import tscr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [START_W-1:0]  start_slot;
   logic [CHAN_W-1:0]   channel;
   logic [PERIOD_W-1:0] repeat_period;

   modport source (output valid, output start_slot, output channel,
                   output repeat_period, input ready);
   modport sink   (input valid, input start_slot, input channel,
                   input repeat_period, output ready);
endinterface

@@ rtl/core/tscr_rsp_if.sv @@
// Response channel interface: grant flag of one reservation.
`timescale 1ns / 1ps

interface tscr_rsp_if
   import tscr_pkg::*;
();
   logic valid;
   logic ready;
   logic granted;

   modport source (output valid, output granted, input ready);
   modport sink   (input valid, input granted, output ready);
endinterface

@@ rtl/core/tdma_slot_channel_reserver.sv @@
// Top level of the TDMA periodic slot channel reserver.
//
//   channel   dir  transfer when       payload
//   req_chan  in   valid && ready     start_slot[11:0] channel[3:0] repeat_period[11:0]
//   rsp_chan  out  valid && ready     granted
//   csr_*     in   csr_wr_en          csr_wr_data[12:0] = superframe length
//
// One request at a time. A request walks its slots twice through the map memory
// (check pass, then set pass), one slot per cycle. A channel number not below
// CHANNELS skips both passes and answers with no grant.
// A conflict ends the check pass early and skips the set pass.
// After reset a clearing pass writes every map entry with req ready low.
// The result waits in an output register; a stalled rsp only holds the next result.
`timescale 1ns / 1ps

module tdma_slot_channel_reserver
   import tscr_pkg::*;
#(
   parameter int unsigned SLOTS    = 4096,
   parameter int unsigned CHANNELS = 16
) (
   input  logic             clock,
   input  logic             reset,
   tscr_req_if.sink         req_chan,
   tscr_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   localparam int unsigned AW = $clog2(SLOTS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Slot map memory
   logic [CHANNELS-1:0] map_mem [SLOTS];
   logic [CHANNELS-1:0] rd_data_ff;

   // Control and payload registers
   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [WALK_W-1:0]   s_ff, s_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [CHANNELS-1:0] mask_ff, mask_in;
   logic                grant_ff, grant_in;
   logic [AW-1:0]       addr_q_ff, addr_q_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [LEN_W-1:0]    len_ff;

   // Memory port controls
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [CHANNELS-1:0] mem_wdata;

   logic [WALK_W-1:0]   len_act;
   logic                walk_end;
   logic [WALK_W-1:0]   s_next;
   logic                conflict;
   logic                req_xfer;

   // Superframe length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   // Active length, limited to the map size
   assign len_act  = (32'(len_ff) > SLOTS) ? WALK_W'(SLOTS) : WALK_W'(len_ff);
   assign walk_end = (s_ff >= len_act);
   assign s_next   = (period_ff == '0) ? len_act : (s_ff + WALK_W'(period_ff));
   assign conflict = rd_vld_ff && ((rd_data_ff & mask_ff) != '0);

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_xfer         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.granted = rsp_granted_ff;

   // Next state and memory access decode
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      s_in           = s_ff;
      start_in       = start_ff;
      period_in      = period_ff;
      mask_in        = mask_ff;
      grant_in       = grant_ff;
      addr_q_in      = addr_q_ff;
      rd_vld_in      = 1'b0;
      rsp_vld_in     = rsp_vld_ff && !rsp_chan.ready;
      rsp_granted_in = rsp_granted_ff;
      mem_re         = 1'b0;
      mem_raddr      = AW'(s_ff);
      mem_we         = 1'b0;
      mem_waddr      = addr_q_ff;
      mem_wdata      = rd_data_ff | mask_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               start_in  = req_chan.start_slot;
               period_in = req_chan.repeat_period;
               s_in      = WALK_W'(req_chan.start_slot);
               mask_in   = CHANNELS'(1) << req_chan.channel;
               if (32'(req_chan.channel) >= CHANNELS) begin
                  grant_in = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // Read one slot a cycle, test the bit in the cycle after its read
            if (!walk_end) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               addr_q_in = AW'(s_ff);
               s_in      = s_next;
            end
            if (conflict) begin
               grant_in = 1'b0;
               state_in = ST_RESP;
            end else if (walk_end && !rd_vld_ff) begin
               s_in     = WALK_W'(start_ff);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // Slots of one walk are distinct, so read and write-back never collide
            if (!walk_end) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               addr_q_in = AW'(s_ff);
               s_in      = s_next;
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
            end
            if (walk_end && !rd_vld_ff) begin
               grant_in = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in     = 1'b1;
               rsp_granted_in = grant_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      s_ff           <= s_in;
      start_ff       <= start_in;
      period_ff      <= period_in;
      mask_ff        <= mask_in;
      grant_ff       <= grant_in;
      addr_q_ff      <= addr_q_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   // Map memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   // Map writes only in the clearing and set passes
   a_we_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_WRITE))
      else $error("map write outside clear or set pass");

   // Returned read data always follows a read issued by a walk
   a_rd_origin: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(mem_re))
      else $error("read data valid without a read");

   // Set pass writes only inside the active superframe
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && mem_we) |-> (WALK_W'(addr_q_ff) < len_act))
      else $error("set pass wrote beyond active length");

   // No request enters while the clearing pass runs
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_chan.ready)
      else $error("request accepted during clearing pass");

endmodule
